FILE: rtl/nqpt_pkg.sv
// ----------------------------------------------------------------------------
// nqpt_pkg
// Shared types, codes and constants of the NVMe queue pair tracker.
// ----------------------------------------------------------------------------
package nqpt_pkg;

   localparam int MAX_DEPTH_DEFAULT = 64;
   localparam int SLOT_W            = 6;
   localparam int DEPTH_CFG_W       = 7;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int CMD_QUEUE_DEPTH   = 2;
   localparam int RSP_QUEUE_DEPTH   = 2;

   // Item opcodes.
   localparam logic [1:0] OPC_SUBMIT   = 2'd0;
   localparam logic [1:0] OPC_COMPLETE = 2'd1;
   localparam logic [1:0] OPC_TICK     = 2'd2;
   localparam logic [1:0] OPC_RSVD     = 2'd3;

   // Result outcomes.
   localparam logic [2:0] OC_SUBMITTED = 3'd0;
   localparam logic [2:0] OC_EMPTY     = 3'd1;
   localparam logic [2:0] OC_OK        = 3'd2;
   localparam logic [2:0] OC_ERROR     = 3'd3;
   localparam logic [2:0] OC_MISMATCH  = 3'd4;
   localparam logic [2:0] OC_TIMEOUT   = 3'd5;
   localparam logic [2:0] OC_REFUSED   = 3'd6;
   localparam logic [2:0] OC_WAITING   = 3'd7;

   // Register indexes, taken from paddr[2].
   localparam logic CSR_IDX_DEPTH   = 1'b0;
   localparam logic CSR_IDX_TIMEOUT = 1'b1;

   localparam logic [DEPTH_CFG_W-1:0] CFG_DEPTH_RESET   = 7'd64;
   localparam logic [31:0]            CFG_TIMEOUT_RESET = 32'd5000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  cmd_opcode;
      logic [15:0] cqe_status;
      logic [15:0] cqe_cid;
      logic [31:0] cqe_result;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [5:0]  slot_index;
      logic [15:0] command_id;
      logic [31:0] command_word0;
      logic [5:0]  doorbell_value;
      logic [31:0] completion_result;
      logic [14:0] status_code;
      logic        failed_flag;
   } rsp_type;

   // Classified item as held between the front and the back.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  cmd_opcode;
      logic        phase;
      logic [14:0] status_code;
      logic        status_nonzero;
      logic [15:0] cid;
      logic [31:0] result;
   } cmd_type;

   typedef struct packed {
      logic [DEPTH_CFG_W-1:0] queue_depth;
      logic [31:0]            timeout_ticks;
   } cfg_type;

endpackage

FILE: rtl/nqpt_fifo.sv
// ----------------------------------------------------------------------------
// nqpt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module nqpt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      do_push  = push & ~full;
      do_pop   = pop & ~empty;
      data_out = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: rtl/nqpt_front.sv
// ----------------------------------------------------------------------------
// nqpt_front
// Accepts request beats, splits the completion status and queues the
// classified item for the back end.
// ----------------------------------------------------------------------------
module nqpt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nqpt_pkg::req_type req_item,
   output logic              full,
   input  logic              cmd_pop,
   output nqpt_pkg::cmd_type cmd,
   output logic              cmd_valid
);

   import nqpt_pkg::*;

   cmd_type                 cmd_new;
   logic [$bits(cmd_type)-1:0] cmd_bits;
   logic                    cmd_empty;

   always_comb begin
      cmd_new.kind           = req_item.opcode;
      cmd_new.cmd_opcode     = req_item.cmd_opcode;
      cmd_new.phase          = req_item.cqe_status[0];
      cmd_new.status_code    = req_item.cqe_status[15:1];
      cmd_new.status_nonzero = |req_item.cqe_status[15:1];
      cmd_new.cid            = req_item.cqe_cid;
      cmd_new.result         = req_item.cqe_result;
   end

   nqpt_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .data_in (cmd_new),
      .full    (full),
      .pop     (cmd_pop),
      .data_out(cmd_bits),
      .empty   (cmd_empty)
   );

   assign cmd       = cmd_type'(cmd_bits);
   assign cmd_valid = ~cmd_empty;

endmodule

FILE: rtl/nqpt_back.sv
// ----------------------------------------------------------------------------
// nqpt_back
// Holds the queue pair state and executes one classified item per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module nqpt_back #(
   parameter int MAX_DEPTH = nqpt_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  nqpt_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  nqpt_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output nqpt_pkg::rsp_type rsp
);

   import nqpt_pkg::*;

   localparam int PTR_W  = $clog2(MAX_DEPTH);
   localparam int CLOG_D = $clog2(MAX_DEPTH + 1);
   localparam int DEP_W  = (CLOG_D > DEPTH_CFG_W) ? CLOG_D : DEPTH_CFG_W;

   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic             phase_ff, phase_in;
   logic [15:0]      next_id_ff, next_id_in;
   logic [15:0]      exp_id_ff, exp_id_in;
   logic             busy_ff, busy_in;
   logic             failed_ff, failed_in;
   logic [31:0]      elapsed_ff, elapsed_in;

   logic             fire;
   logic [DEP_W-1:0] qd_ext;
   logic [DEP_W-1:0] depth;
   logic             tail_wrap;
   logic             head_wrap;
   logic [PTR_W-1:0] tail_adv;
   logic [PTR_W-1:0] head_adv;
   logic [31:0]      elapsed_inc;

   assign fire     = cmd_valid & ~rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;

   always_comb begin
      qd_ext = DEP_W'(cfg.queue_depth);
      if (qd_ext < DEP_W'(2)) begin
         depth = DEP_W'(2);
      end else if (qd_ext > DEP_W'(MAX_DEPTH)) begin
         depth = DEP_W'(MAX_DEPTH);
      end else begin
         depth = qd_ext;
      end

      tail_wrap   = (DEP_W'(tail_ff) + DEP_W'(1)) >= depth;
      head_wrap   = (DEP_W'(head_ff) + DEP_W'(1)) >= depth;
      tail_adv    = tail_wrap ? '0 : tail_ff + 1'b1;
      head_adv    = head_wrap ? '0 : head_ff + 1'b1;
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
   end

   always_comb begin
      tail_in    = tail_ff;
      head_in    = head_ff;
      phase_in   = phase_ff;
      next_id_in = next_id_ff;
      exp_id_in  = exp_id_ff;
      busy_in    = busy_ff;
      failed_in  = failed_ff;
      elapsed_in = elapsed_ff;
      rsp        = '0;

      case (cmd.kind)
         OPC_SUBMIT: begin
            if (failed_ff | busy_ff) begin
               rsp.outcome = OC_REFUSED;
            end else begin
               rsp.outcome        = OC_SUBMITTED;
               rsp.slot_index     = SLOT_W'(tail_ff);
               rsp.command_id     = next_id_ff;
               rsp.command_word0  = {next_id_ff, 8'h00, cmd.cmd_opcode};
               rsp.doorbell_value = SLOT_W'(tail_adv);
               next_id_in         = next_id_ff + 16'd1;
               tail_in            = tail_adv;
               exp_id_in          = next_id_ff;
               busy_in            = 1'b1;
               elapsed_in         = '0;
            end
         end
         OPC_COMPLETE: begin
            if (cmd.phase != phase_ff) begin
               rsp.outcome = OC_EMPTY;
            end else begin
               rsp.completion_result = cmd.result;
               rsp.status_code       = cmd.status_code;
               rsp.doorbell_value    = SLOT_W'(head_adv);
               head_in               = head_adv;
               // The expected phase flips each time the head wraps.
               phase_in              = phase_ff ^ head_wrap;
               if (~busy_ff || (cmd.cid != exp_id_ff)) begin
                  failed_in   = 1'b1;
                  rsp.outcome = OC_MISMATCH;
               end else begin
                  rsp.outcome = cmd.status_nonzero ? OC_ERROR : OC_OK;
               end
               busy_in = 1'b0;
            end
         end
         OPC_TICK: begin
            if (busy_ff) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= cfg.timeout_ticks) begin
                  failed_in   = 1'b1;
                  busy_in     = 1'b0;
                  rsp.outcome = OC_TIMEOUT;
               end else begin
                  rsp.outcome = OC_WAITING;
               end
            end else begin
               rsp.outcome = OC_EMPTY;
            end
         end
         default: begin
            rsp.outcome = OC_REFUSED;
         end
      endcase

      rsp.failed_flag = failed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff    <= '0;
         head_ff    <= '0;
         phase_ff   <= 1'b1;
         next_id_ff <= '0;
         exp_id_ff  <= '0;
         busy_ff    <= 1'b0;
         failed_ff  <= 1'b0;
         elapsed_ff <= '0;
      end else if (fire) begin
         tail_ff    <= tail_in;
         head_ff    <= head_in;
         phase_ff   <= phase_in;
         next_id_ff <= next_id_in;
         exp_id_ff  <= exp_id_in;
         busy_ff    <= busy_in;
         failed_ff  <= failed_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

FILE: rtl/nqpt_csr.sv
// ----------------------------------------------------------------------------
// nqpt_csr
// APB register file holding the queue depth and the timeout in ticks.
// ----------------------------------------------------------------------------
module nqpt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nqpt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [nqpt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [nqpt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output nqpt_pkg::cfg_type                   cfg
);

   import nqpt_pkg::*;

   logic [DEPTH_CFG_W-1:0] depth_ff, depth_in;
   logic [31:0]            timeout_ff, timeout_in;
   logic                   wr_en;
   logic                   reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      depth_in   = depth_ff;
      timeout_in = timeout_ff;
      prdata     = '0;
      case (reg_idx)
         CSR_IDX_DEPTH: begin
            prdata = CSR_DATA_W'(depth_ff);
            if (wr_en) begin
               depth_in = pwdata[DEPTH_CFG_W-1:0];
            end
         end
         CSR_IDX_TIMEOUT: begin
            prdata = timeout_ff;
            if (wr_en) begin
               timeout_in = pwdata;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= CFG_DEPTH_RESET;
         timeout_ff <= CFG_TIMEOUT_RESET;
      end else begin
         depth_ff   <= depth_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.queue_depth   = depth_ff;
   assign cfg.timeout_ticks = timeout_ff;

endmodule

FILE: rtl/nvme_queue_pair_tracker_core.sv
// Path: a request beat is registered in the command queue, executed by the back end and
// registered in the result queue, from which its result is taken.
// Throughput: one item per cycle; the back end executes one queued item each
// cycle that the two-entry result queue has room.
// Reset: synchronous; clears both queues and the queue pair state and loads
// the register reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
// nvme_queue_pair_tracker_core
// Host-side tracker of one NVMe submission/completion queue pair.
// ----------------------------------------------------------------------------
module nvme_queue_pair_tracker_core #(
   parameter int MAX_DEPTH = nqpt_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  nqpt_pkg::req_type               req_item,
   output logic                            full,
   output logic                            empty,
   input  logic                            pop,
   output nqpt_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [nqpt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [nqpt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [nqpt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   import nqpt_pkg::*;

   cfg_type                    cfg;
   cmd_type                    cmd;
   logic                       cmd_valid;
   logic                       cmd_pop;
   rsp_type                    rsp_new;
   logic                       rsp_push;
   logic                       rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   nqpt_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   nqpt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .cmd_pop  (cmd_pop),
      .cmd      (cmd),
      .cmd_valid(cmd_valid)
   );

   nqpt_back #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_new)
   );

   nqpt_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .data_in (rsp_new),
      .full    (rsp_full),
      .pop     (pop),
      .data_out(rsp_bits),
      .empty   (empty)
   );

   assign rsp_item = rsp_type'(rsp_bits);

endmodule

FILE: rtl/nqpt_checker.sv
// ----------------------------------------------------------------------------
// nqpt_checker
// Port-level checks of the queue pair tracker, bound to the top level.
// ----------------------------------------------------------------------------
module nqpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              empty,
   input logic              pop,
   input nqpt_pkg::rsp_type rsp_item
);

   import nqpt_pkg::*;

   // Reset empties the result side.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result changed before its beat");

   // Failure is sticky: every later result reports it until reset.
   a_sticky_failed: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_item.failed_flag) |=> (empty || rsp_item.failed_flag))
      else $error("failed flag dropped");

   a_submit_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.outcome == OC_SUBMITTED) |->
         (rsp_item.command_word0[31:16] == rsp_item.command_id &&
          rsp_item.command_word0[15:8] == 8'h00 &&
          rsp_item.completion_result == 32'd0))
      else $error("submit result carries a bad command word");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_item.outcome == OC_EMPTY || rsp_item.outcome == OC_REFUSED ||
                  rsp_item.outcome == OC_WAITING || rsp_item.outcome == OC_TIMEOUT)) |->
         (rsp_item.slot_index == '0 && rsp_item.command_id == '0 &&
          rsp_item.command_word0 == '0 && rsp_item.doorbell_value == '0 &&
          rsp_item.completion_result == '0 && rsp_item.status_code == '0))
      else $error("non-data result carries payload");

endmodule

bind nvme_queue_pair_tracker_core nqpt_checker u_checker (
   .clock   (clock),
   .reset   (reset),
   .empty   (empty),
   .pop     (pop),
   .rsp_item(rsp_item)
);

FILE: verif/nqpt_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqpt_test_pkg
// Scoreboard of the queue pair tracker test. It keeps its own copy of the
// queue pair state, works out the result of every accepted request beat and
// compares each result beat with the oldest expected one.
// ----------------------------------------------------------------------------
package nqpt_test_pkg;

   import nqpt_pkg::*;

   class qpair_scoreboard_type;
      int unsigned max_depth;
      logic [6:0]  depth_cfg;
      logic [31:0] timeout_cfg;
      int unsigned tail;
      int unsigned head;
      logic        phase;
      logic [15:0] next_id;
      logic [15:0] expected_id;
      bit          busy;
      bit          failed;
      logic [31:0] elapsed;
      rsp_type     awaited_results[$];
      int unsigned failures;

      function new(int unsigned depth_limit);
         max_depth   = depth_limit;
         depth_cfg   = CFG_DEPTH_RESET;
         timeout_cfg = CFG_TIMEOUT_RESET;
         tail        = 0;
         head        = 0;
         phase       = 1'b1;
         next_id     = '0;
         expected_id = '0;
         busy        = 1'b0;
         failed      = 1'b0;
         elapsed     = '0;
         failures    = 0;
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == CSR_IDX_DEPTH) begin
            depth_cfg = value[6:0];
         end else begin
            timeout_cfg = value;
         end
      endfunction

      function int unsigned results_awaited();
         return awaited_results.size();
      endfunction

      // Applies one request beat to the local state and queues its result.
      function void note_request(req_type req);
         rsp_type     want;
         int unsigned ring;
         want = '0;
         ring = depth_cfg;
         if (ring < 2) ring = 2;
         if (ring > max_depth) ring = max_depth;
         case (req.opcode)
            OPC_SUBMIT: begin
               if (failed || busy) begin
                  want.outcome = OC_REFUSED;
               end else begin
                  want.outcome       = OC_SUBMITTED;
                  want.slot_index    = tail[5:0];
                  want.command_id    = next_id;
                  want.command_word0 = {next_id, 8'h00, req.cmd_opcode};
                  expected_id        = next_id;
                  next_id            = next_id + 16'd1;
                  tail               = (tail + 1 >= ring) ? 0 : tail + 1;
                  want.doorbell_value = tail[5:0];
                  busy               = 1'b1;
                  elapsed            = '0;
               end
            end
            OPC_COMPLETE: begin
               if (req.cqe_status[0] != phase) begin
                  want.outcome = OC_EMPTY;
               end else begin
                  want.completion_result = req.cqe_result;
                  want.status_code       = req.cqe_status[15:1];
                  // The completion ring flips its phase tag on every wrap.
                  if (head + 1 >= ring) begin
                     head  = 0;
                     phase = ~phase;
                  end else begin
                     head = head + 1;
                  end
                  want.doorbell_value = head[5:0];
                  if (!busy || req.cqe_cid != expected_id) begin
                     failed       = 1'b1;
                     want.outcome = OC_MISMATCH;
                  end else if (req.cqe_status[15:1] != '0) begin
                     want.outcome = OC_ERROR;
                  end else begin
                     want.outcome = OC_OK;
                  end
                  busy = 1'b0;
               end
            end
            OPC_TICK: begin
               if (busy) begin
                  if (elapsed != 32'hffff_ffff) elapsed = elapsed + 32'd1;
                  if (elapsed >= timeout_cfg) begin
                     failed       = 1'b1;
                     busy         = 1'b0;
                     want.outcome = OC_TIMEOUT;
                  end else begin
                     want.outcome = OC_WAITING;
                  end
               end else begin
                  want.outcome = OC_EMPTY;
               end
            end
            default: want.outcome = OC_REFUSED;
         endcase
         want.failed_flag = failed;
         awaited_results.push_back(want);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            $error("result beat with nothing expected, outcome %0d", got.outcome);
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("outcome", want.outcome, got.outcome);
         compare_field("slot_index", want.slot_index, got.slot_index);
         compare_field("command_id", want.command_id, got.command_id);
         compare_field("command_word0", want.command_word0, got.command_word0);
         compare_field("doorbell_value", want.doorbell_value, got.doorbell_value);
         compare_field("completion_result", want.completion_result,
                       got.completion_result);
         compare_field("status_code", want.status_code, got.status_code);
         compare_field("failed_flag", want.failed_flag, got.failed_flag);
      endfunction
   endclass

endpackage

FILE: verif/nvme_queue_pair_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvme_queue_pair_tracker_core_test
// Drives submits, completion entries and ticks into the queue pair tracker
// under several ring depths and timeouts, with random idling on both sides,
// and checks every result beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module nvme_queue_pair_tracker_core_test;

   import nqpt_pkg::*;
   import nqpt_test_pkg::*;

   localparam int          DEPTH_LIMIT      = MAX_DEPTH_DEFAULT;
   localparam int          ITEMS_PER_PHASE  = 170;
   localparam int          LONG_HOLD_CYCLES = 150;
   localparam int          NOISE_ITEMS      = 60;
   localparam int          CALM_PAIRS       = 20;
   localparam int unsigned RUN_LIMIT_NS     = 4_000_000;

   typedef enum int {
      FAIL_BY_ID,
      FAIL_BY_ZERO_TIMEOUT,
      FAIL_BY_TICKS,
      FAIL_BY_STRAY_ENTRY
   } failure_route_type;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  push     = 1'b0;
   req_type               req_item = '0;
   logic                  full;
   logic                  empty;
   logic                  pop      = 1'b0;
   rsp_type               rsp_item;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr    = '0;
   logic [CSR_DATA_W-1:0] pwdata   = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   qpair_scoreboard_type sb;
   bit              calm             = 1'b0;
   bit              hold_off_request = 1'b0;
   int unsigned     gap_percent      = 0;
   int unsigned     stall_percent    = 0;

   nvme_queue_pair_tracker_core #(
      .MAX_DEPTH(DEPTH_LIMIT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .req_item(req_item),
      .full    (full),
      .empty   (empty),
      .pop     (pop),
      .rsp_item(rsp_item),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_response(rsp_item);
   end

   // Result side: short random stalls, or one long hold-off on request.
   initial begin : result_taker
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
            pop <= 1'b1;
         end else if (!calm && $urandom_range(99) < stall_percent) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            pop <= 1'b1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [7:0] cmd,
                                        logic [15:0] status, logic [15:0] cid,
                                        logic [31:0] result);
      req_type r;
      r.opcode     = op;
      r.cmd_opcode = cmd;
      r.cqe_status = status;
      r.cqe_cid    = cid;
      r.cqe_result = result;
      return r;
   endfunction

   // Completion entry that the tracker takes and matches to the command in flight.
   function automatic req_type matching_completion();
      req_type r;
      r = make_req(OPC_COMPLETE, 8'($urandom()), 16'($urandom()), sb.expected_id,
                   $urandom());
      if ($urandom_range(2) == 0) r.cqe_status[15:1] = '0;
      r.cqe_status[0] = sb.phase;
      return r;
   endfunction

   // Well-formed traffic: it never sets the sticky failure.
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r = make_req(OPC_TICK, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                   $urandom());
      pick = $urandom_range(99);
      if (pick < 5) begin
         r.opcode = OPC_RSVD;
      end else if (pick < 20) begin
         // Entry not yet written by the device: stale phase tag.
         r.opcode = OPC_COMPLETE;
         r.cqe_status[0] = ~sb.phase;
      end else if (sb.busy) begin
         if (pick < 35 && sb.timeout_cfg != '0 && sb.elapsed < sb.timeout_cfg - 32'd1) begin
            r.opcode = OPC_TICK;
         end else if (pick < 45) begin
            r.opcode = OPC_SUBMIT;
         end else begin
            r = matching_completion();
         end
      end else if (pick < 35) begin
         r.opcode = OPC_TICK;
      end else begin
         r.opcode = OPC_SUBMIT;
      end
      return r;
   endfunction

   task automatic send_item(input req_type r);
      req_item <= r;
      push     <= 1'b1;
      do @(posedge clock); while (full !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic idle_input(input int unsigned cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      push <= 1'b0;
      while (sb.results_awaited() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_register(idx, value);
   endtask

   initial begin : stimulus
      logic [6:0]        phase_depths [4];
      logic [31:0]       phase_timeouts [4];
      failure_route_type route;
      req_type           r;

      sb = new(DEPTH_LIMIT);
      phase_depths   = '{7'd127, 7'd2, 7'd64, 7'($urandom_range(127))};
      phase_timeouts = '{32'hffff_ffff, 32'd1, 32'd3, 32'd5000};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset configuration.
      send_item(make_req(OPC_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000));
      send_item(make_req(OPC_COMPLETE, 8'hff, 16'hfffe, 16'hffff, 32'hffff_ffff));
      send_item(make_req(OPC_RSVD, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff));
      send_item(make_req(OPC_SUBMIT, 8'hff, 16'h0000, 16'h0000, 32'h0000_0000));
      send_item(make_req(OPC_SUBMIT, 8'h00, 16'hffff, 16'hffff, 32'hffff_ffff));
      send_item(make_req(OPC_TICK, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff));
      send_item(make_req(OPC_COMPLETE, 8'h00, 16'hffff, sb.expected_id, 32'hffff_ffff));
      send_item(make_req(OPC_SUBMIT, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000));
      send_item(make_req(OPC_COMPLETE, 8'h00, 16'h0001, sb.expected_id, 32'h0000_0000));

      // A depth below the minimum clamps to two; the tail is already past it.
      drain_results();
      write_csr(CSR_IDX_DEPTH, 32'd0);
      repeat (3) begin
         send_item(make_req(OPC_SUBMIT, 8'($urandom()), '0, '0, '0));
         send_item(matching_completion());
      end

      for (int p = 0; p < 4; p++) begin
         drain_results();
         write_csr(CSR_IDX_DEPTH, 32'(phase_depths[p]));
         write_csr(CSR_IDX_TIMEOUT, phase_timeouts[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               gap_percent   = 15 * $urandom_range(2);
               stall_percent = 15 * $urandom_range(2);
            end
            // The sender keeps offering beats so the block fills and stalls.
            if (p == 2 && n == 50) hold_off_request = 1'b1;
            send_item(random_request());
            if ($urandom_range(99) < gap_percent) idle_input($urandom_range(1, 11));
         end
      end

      // Last part without idling: submit and completion pairs back to back.
      calm          = 1'b1;
      gap_percent   = 0;
      stall_percent = 0;
      drain_results();
      write_csr(CSR_IDX_DEPTH, 32'($urandom_range(2, 64)));
      if (sb.busy) send_item(matching_completion());
      repeat (CALM_PAIRS) begin
         send_item(make_req(OPC_SUBMIT, 8'($urandom()), '0, '0, '0));
         send_item(matching_completion());
      end

      // Only one way into the sticky failure is taken per run, picked at random.
      drain_results();
      route = failure_route_type'($urandom_range(3));
      case (route)
         FAIL_BY_ID: begin
            send_item(make_req(OPC_SUBMIT, 8'($urandom()), '0, '0, '0));
            send_item(make_req(OPC_COMPLETE, 8'h00,
                               {15'($urandom_range(1, 32767)), sb.phase},
                               sb.expected_id ^ 16'($urandom_range(1, 65535)),
                               $urandom()));
         end
         FAIL_BY_ZERO_TIMEOUT: begin
            write_csr(CSR_IDX_TIMEOUT, 32'd0);
            send_item(make_req(OPC_SUBMIT, 8'($urandom()), '0, '0, '0));
            send_item(make_req(OPC_TICK, '0, '0, '0, '0));
         end
         FAIL_BY_TICKS: begin
            write_csr(CSR_IDX_TIMEOUT, 32'd3);
            send_item(make_req(OPC_SUBMIT, 8'($urandom()), '0, '0, '0));
            repeat (3) send_item(make_req(OPC_TICK, '0, '0, '0, '0));
         end
         default: begin
            send_item(make_req(OPC_COMPLETE, 8'h00, {15'($urandom()), sb.phase},
                               16'($urandom()), $urandom()));
         end
      endcase
      send_item(make_req(OPC_SUBMIT, 8'($urandom()), '0, '0, '0));
      send_item(make_req(OPC_COMPLETE, 8'h00, {15'($urandom()), sb.phase},
                         sb.expected_id, $urandom()));
      send_item(make_req(OPC_TICK, '0, '0, '0, '0));
      repeat (NOISE_ITEMS) begin
         r = make_req(2'($urandom_range(3)), 8'($urandom()), 16'($urandom()),
                      16'($urandom()), $urandom());
         if ($urandom_range(1) == 0) r.cqe_status[0] = sb.phase;
         send_item(r);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.results_awaited() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
